// ----- src/plt_pkg.sv -----
// ============================================================================
// plt_pkg
// Shared types, defaults and the sine table builder for the planar transform.
// ============================================================================
package plt_pkg;

    // Default geometry of the top level.
    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_BITS_DEF  = 12;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 16;

    // Sine and cosine are Q1.15 magnitudes.
    localparam int TRIG_W = 16;

    // pi in Q30, used to build the quarter-wave table.
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Taylor series denominators (2n)(2n+1) for n = 1..8.
    localparam longint unsigned TAYLOR_DIV [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Magnitudes and signs of sine and cosine, as read from the table.
    typedef struct packed {
        logic [TRIG_W-1:0] sin_mag;
        logic [TRIG_W-1:0] cos_mag;
        logic              sin_neg;
        logic              cos_neg;
    } trig_t;

    // Entry k of the quarter-wave table: sin(k * pi / 2^(angle_bits-1)) in
    // Q15, rounded, with the unit value held at 32767.
    function automatic logic [TRIG_W-1:0] quarter_entry(input int unsigned k,
                                                        input int unsigned angle_bits);
        longint unsigned th;
        longint unsigned th2;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        int              n;
        th   = (longint'(k) * PI_Q30 + (64'd1 << (angle_bits - 2))) >> (angle_bits - 1);
        th2  = (th * th) >> 30;
        term = th;
        sum  = longint'(th);
        for (n = 1; n <= 8; n++) begin
            term = (term * th2) >> 30;
            term = term / TAYLOR_DIV[n];
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (longint'(sum) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[TRIG_W-1:0];
    endfunction

endpackage

// ----- src/plt_sincos.sv -----
// ============================================================================
// plt_sincos
// Quarter-wave sine ROM with two registered read ports, one for sine and one
// for cosine of the same angle.
// ============================================================================
module plt_sincos #(
    parameter int ANGLE_BITS = plt_pkg::ANGLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [ANGLE_BITS-1:0] angle_i,
    output plt_pkg::trig_t        trig_o
);

    localparam int QTR   = 1 << (ANGLE_BITS - 2);
    localparam int DEPTH = QTR + 1;
    localparam int AW    = ANGLE_BITS - 1;

    typedef logic [plt_pkg::TRIG_W-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t tbl;
        for (int k = 0; k < DEPTH; k++) begin
            tbl[k] = plt_pkg::quarter_entry(k, ANGLE_BITS);
        end
        return tbl;
    endfunction

    localparam rom_t ROM_TABLE = build_rom();

    logic [ANGLE_BITS-1:0] cos_angle;
    logic [AW-1:0]         sin_idx;
    logic [AW-1:0]         cos_idx;
    plt_pkg::trig_t        trig_reg;

    // Map an angle onto the first quadrant; odd quadrants read the mirror entry.
    function automatic logic [AW-1:0] quad_index(input logic [ANGLE_BITS-1:0] a);
        logic [AW-1:0] r;
        r = {1'b0, a[ANGLE_BITS-3:0]};
        if (a[ANGLE_BITS-2]) begin
            return AW'(QTR) - r;
        end
        return r;
    endfunction

    // Cosine is sine a quarter turn ahead, wrapping around the circle.
    assign cos_angle = angle_i + ANGLE_BITS'(QTR);
    assign sin_idx   = quad_index(angle_i);
    assign cos_idx   = quad_index(cos_angle);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            trig_reg.sin_mag <= ROM_TABLE[sin_idx];
            trig_reg.cos_mag <= ROM_TABLE[cos_idx];
            trig_reg.sin_neg <= angle_i[ANGLE_BITS-1];
            trig_reg.cos_neg <= cos_angle[ANGLE_BITS-1];
        end
    end

    assign trig_o = trig_reg;

endmodule

// ----- src/planar_linear_transform.sv -----
// ============================================================================
// planar_linear_transform
// Rotates, reflects, projects or shears one 2D point per beat.
// ============================================================================
//
//  Channel   Direction  Contents
//  --------  ---------  ---------------------------------------------------
//  s_*       in         point beat: tdata = x_in, y_in
//  m_*       out        result beat: tdata = x_out, y_out; tuser = clipped
//  cfg_*     in         register write: 0 mode, 1 angle, 2 shear_axis,
//                       3 shear_gain
//
//  A new point is taken every cycle unless the result beat is held. The five
//  stages are: sine ROM read, coefficient build (where the projection squares
//  sine and cosine), the four matrix multiplies, the two row sums with the
//  rounding bias, and the shift with saturation into the output register.
//  All stages advance together; when the result beat is held by the sink,
//  the whole pipeline freezes and s_tready drops, so nothing is lost or
//  repeated. Reset is synchronous and clears the valid bits and config registers.
//  Registers may only be written while no point is in flight.
//
module planar_linear_transform #(
    parameter int COORD_WIDTH = plt_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_BITS  = plt_pkg::ANGLE_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,

    // Fields from bit 0 up: x_in, y_in, zero fill.
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,

    // Fields from bit 0 up: x_out, y_out, zero fill.
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]       m_tdata,
    // Fields from bit 0 up: clipped.
    output logic                                     m_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,

    input  logic                                     cfg_wr_en,
    input  logic [plt_pkg::CFG_ADDR_W-1:0]           cfg_addr,
    input  logic [plt_pkg::CFG_DATA_W-1:0]           cfg_wdata
);

    localparam int W       = COORD_WIDTH;
    localparam int DATA_W  = ((2*COORD_WIDTH+7)/8)*8;
    localparam int COEF_W  = 2 * plt_pkg::TRIG_W;
    localparam int PROD_W  = COEF_W + W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int TW      = plt_pkg::TRIG_W;
    localparam int GW      = plt_pkg::GAIN_W;

    // Fraction bits of the three coefficient formats.
    localparam int SH_SHEAR = 8;
    localparam int SH_Q15   = 15;
    localparam int SH_Q30   = 30;

    localparam logic signed [SUM_W-1:0] BIAS_SHEAR = SUM_W'(1) <<< (SH_SHEAR - 1);
    localparam logic signed [SUM_W-1:0] BIAS_Q15   = SUM_W'(1) <<< (SH_Q15 - 1);
    localparam logic signed [SUM_W-1:0] BIAS_Q30   = SUM_W'(1) <<< (SH_Q30 - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI     = (SUM_W'(1) <<< (W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO     = ~SAT_HI;
    localparam logic signed [COEF_W-1:0] UNIT_Q8   = COEF_W'(1) <<< SH_SHEAR;

    typedef enum logic [1:0] {
        MODE_ROTATE  = 2'd0,
        MODE_REFLECT = 2'd1,
        MODE_PROJECT = 2'd2,
        MODE_SHEAR   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODE       = 2'd0,
        CFG_ANGLE      = 2'd1,
        CFG_SHEAR_AXIS = 2'd2,
        CFG_SHEAR_GAIN = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SHIFT_SHEAR,
        SHIFT_Q15,
        SHIFT_Q30
    } shift_t;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    mode_t                  mode_reg;
    logic [ANGLE_BITS-1:0]  angle_reg;
    logic                   axis_reg;
    logic signed [GW-1:0]   gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_ROTATE;
            angle_reg <= '0;
            axis_reg  <= 1'b0;
            gain_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MODE:       mode_reg  <= mode_t'(cfg_wdata[1:0]);
                CFG_ANGLE:      angle_reg <= cfg_wdata[ANGLE_BITS-1:0];
                CFG_SHEAR_AXIS: axis_reg  <= cfg_wdata[0];
                CFG_SHEAR_GAIN: gain_reg  <= cfg_wdata[GW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves when the output slot is free.
    // ------------------------------------------------------------------
    logic pipe_en;
    logic m_valid_reg;

    assign pipe_en  = !m_valid_reg || m_tready;
    assign s_tready = pipe_en;

    // ------------------------------------------------------------------
    // Stage 1: sine and cosine ROM read. Reflection uses the doubled angle.
    // ------------------------------------------------------------------
    logic [ANGLE_BITS-1:0]   trig_angle;
    plt_pkg::trig_t          trig;
    logic                    v1_reg;
    logic signed [W-1:0]     x1_reg, y1_reg;

    assign trig_angle = (mode_reg == MODE_REFLECT) ? {angle_reg[ANGLE_BITS-2:0], 1'b0}
                                                   : angle_reg;

    plt_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sincos (
        .aclk    (aclk),
        .rd_en   (pipe_en),
        .angle_i (trig_angle),
        .trig_o  (trig)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_tvalid;
        end
        if (pipe_en) begin
            x1_reg <= s_tdata[W-1:0];
            y1_reg <= s_tdata[2*W-1:W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: signed sine and cosine, and the 2x2 matrix for the mode.
    // ------------------------------------------------------------------
    logic signed [TW-1:0]     cs, sn;
    logic signed [COEF_W-1:0] cc, cxs, ss;
    logic signed [COEF_W-1:0] a11_next, a12_next, a21_next, a22_next;
    shift_t                   sh_next;
    logic signed [COEF_W-1:0] a11_reg, a12_reg, a21_reg, a22_reg;
    shift_t                   sh2_reg;
    logic                     v2_reg;
    logic signed [W-1:0]      x2_reg, y2_reg;

    assign cs  = trig.cos_neg ? -$signed(trig.cos_mag) : $signed(trig.cos_mag);
    assign sn  = trig.sin_neg ? -$signed(trig.sin_mag) : $signed(trig.sin_mag);
    assign cc  = cs * cs;
    assign cxs = cs * sn;
    assign ss  = sn * sn;

    always_comb begin
        a11_next = COEF_W'(cs);
        a12_next = -COEF_W'(sn);
        a21_next = COEF_W'(sn);
        a22_next = COEF_W'(cs);
        sh_next  = SHIFT_Q15;
        case (mode_reg)
            MODE_ROTATE: begin
                a11_next = COEF_W'(cs);
                a12_next = -COEF_W'(sn);
                a21_next = COEF_W'(sn);
                a22_next = COEF_W'(cs);
                sh_next  = SHIFT_Q15;
            end
            MODE_REFLECT: begin
                // Cosine and sine here are those of twice the angle.
                a11_next = COEF_W'(cs);
                a12_next = COEF_W'(sn);
                a21_next = COEF_W'(sn);
                a22_next = -COEF_W'(cs);
                sh_next  = SHIFT_Q15;
            end
            MODE_PROJECT: begin
                a11_next = cc;
                a12_next = cxs;
                a21_next = cxs;
                a22_next = ss;
                sh_next  = SHIFT_Q30;
            end
            MODE_SHEAR: begin
                // Identity in Q8.8 with the gain placed off the diagonal.
                a11_next = UNIT_Q8;
                a12_next = axis_reg ? COEF_W'(gain_reg) : '0;
                a21_next = axis_reg ? '0 : COEF_W'(gain_reg);
                a22_next = UNIT_Q8;
                sh_next  = SHIFT_SHEAR;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (pipe_en) begin
            v2_reg <= v1_reg;
        end
        if (pipe_en) begin
            a11_reg <= a11_next;
            a12_reg <= a12_next;
            a21_reg <= a21_next;
            a22_reg <= a22_next;
            sh2_reg <= sh_next;
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the four matrix products.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] p11_reg, p12_reg, p21_reg, p22_reg;
    shift_t                   sh3_reg;
    logic                     v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (pipe_en) begin
            v3_reg <= v2_reg;
        end
        if (pipe_en) begin
            p11_reg <= PROD_W'(a11_reg) * PROD_W'(x2_reg);
            p12_reg <= PROD_W'(a12_reg) * PROD_W'(y2_reg);
            p21_reg <= PROD_W'(a21_reg) * PROD_W'(x2_reg);
            p22_reg <= PROD_W'(a22_reg) * PROD_W'(y2_reg);
            sh3_reg <= sh2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: row sums with the round-half-up bias added in.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] tx_reg, ty_reg;
    shift_t                  sh4_reg;
    logic                    v4_reg;

    always_comb begin
        case (sh3_reg)
            SHIFT_SHEAR: bias = BIAS_SHEAR;
            SHIFT_Q30:   bias = BIAS_Q30;
            default:     bias = BIAS_Q15;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (pipe_en) begin
            v4_reg <= v3_reg;
        end
        if (pipe_en) begin
            tx_reg  <= SUM_W'(p11_reg) + SUM_W'(p12_reg) + bias;
            ty_reg  <= SUM_W'(p21_reg) + SUM_W'(p22_reg) + bias;
            sh4_reg <= sh3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: drop the fraction (floor after the bias gives round to
    // nearest, ties upward), saturate, and hold the result beat.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] rx, ry;
    logic signed [W-1:0]     x_sat, y_sat;
    logic                    x_clip, y_clip;
    logic signed [W-1:0]     x_out_reg, y_out_reg;
    logic                    clip_reg;

    always_comb begin
        case (sh4_reg)
            SHIFT_SHEAR: begin
                rx = tx_reg >>> SH_SHEAR;
                ry = ty_reg >>> SH_SHEAR;
            end
            SHIFT_Q30: begin
                rx = tx_reg >>> SH_Q30;
                ry = ty_reg >>> SH_Q30;
            end
            default: begin
                rx = tx_reg >>> SH_Q15;
                ry = ty_reg >>> SH_Q15;
            end
        endcase
    end

    always_comb begin
        x_clip = 1'b1;
        y_clip = 1'b1;
        if (rx > SAT_HI) begin
            x_sat = SAT_HI[W-1:0];
        end else if (rx < SAT_LO) begin
            x_sat = SAT_LO[W-1:0];
        end else begin
            x_sat  = rx[W-1:0];
            x_clip = 1'b0;
        end
        if (ry > SAT_HI) begin
            y_sat = SAT_HI[W-1:0];
        end else if (ry < SAT_LO) begin
            y_sat = SAT_LO[W-1:0];
        end else begin
            y_sat  = ry[W-1:0];
            y_clip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= v4_reg;
        end
        if (pipe_en) begin
            x_out_reg <= x_sat;
            y_out_reg <= y_sat;
            clip_reg  <= x_clip || y_clip;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'({y_out_reg, x_out_reg});
    assign m_tuser  = clip_reg;

`ifndef SYNTH
    // A held result beat freezes every stage behind it.
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> ($stable(v1_reg) && $stable(v4_reg)
                                        && $stable(tx_reg) && $stable(x1_reg)))
        else $error("pipeline moved while the result beat was stalled");

    // The clip flag marks a coordinate sitting on a saturation bound.
    a_clip_at_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && clip_reg) |->
            (x_out_reg == SAT_HI[W-1:0] || x_out_reg == SAT_LO[W-1:0] ||
             y_out_reg == SAT_HI[W-1:0] || y_out_reg == SAT_LO[W-1:0]))
        else $error("clip flag set on an unsaturated result");

    // A result beat only appears from a valid item in the last stage.
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v4_reg))
        else $error("result beat appeared without an item behind it");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg))
        else $error("pipeline not empty after reset");
`endif

endmodule

// ----- verif/planar_linear_transform_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// planar_linear_transform_test
// Self-checking bench for the planar point transform.
// A short table of hand-picked register writes and points comes first. After
// it, random settings are applied with runs of random points under three
// idling patterns. Every result beat is checked against a model of the
// transform kept in the bench, in beat order.
// ============================================================================
module planar_linear_transform_test;

    import plt_pkg::*;

    // Geometry of the block as instantiated (default parameters).
    localparam int COORD_W    = COORD_WIDTH_DEF;
    localparam int ANGLE_BITS = ANGLE_BITS_DEF;
    localparam int TDATA_W    = ((2 * COORD_W + 7) / 8) * 8;
    localparam int QUARTER    = 1 << (ANGLE_BITS - 2);

    localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // pi in Q30; the sine table below is rebuilt from it independently.
    localparam longint unsigned PI_Q30_BENCH = 64'd3373259426;

    // Number of pipeline stages in the block, taken from its header.
    localparam int PIPE_DEPTH = 5;

    // Random part: three idling phases, each a run of register settings.
    localparam int SETTINGS_PER_PHASE = 10;
    localparam int POINTS_PER_SETTING = 50;

    // Length of the one long hold-off of the result channel.
    localparam int LONG_HOLD_CYCLES = 120;

    // Hard stop, far beyond the slowest correct run.
    localparam int TIMEOUT_NS = 2_000_000;

    typedef enum logic [1:0] {
        MODE_ROTATE  = 2'd0,
        MODE_REFLECT = 2'd1,
        MODE_PROJECT = 2'd2,
        MODE_SHEAR   = 2'd3
    } map_mode_t;

    typedef enum logic [1:0] {
        REG_MODE       = 2'd0,
        REG_ANGLE      = 2'd1,
        REG_SHEAR_AXIS = 2'd2,
        REG_SHEAR_GAIN = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      clipped;
    } point_result_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_POINT
    } row_kind_t;

    // One row of the directed table: either a register write or a point.
    // A point row with typed set carries its expected result by hand.
    typedef struct {
        row_kind_t                 kind;
        reg_index_t                reg_idx;
        logic [CFG_DATA_W-1:0]     value;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        bit                        typed;
        point_result_t             want;
    } directed_row_t;

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Bench copy of the block's registers, updated as each write lands.
    map_mode_t               cur_mode  = MODE_ROTATE;
    logic [ANGLE_BITS-1:0]   cur_angle = '0;
    logic                    cur_axis  = 1'b0;
    logic signed [GAIN_W-1:0] cur_gain = '0;

    // Quarter-wave sine magnitudes in Q15, entry k for k * (pi/2) / QUARTER.
    longint sine_quarter [0:QUARTER];

    // Points accepted by the block whose result beat has not yet come back.
    point_result_t pending_points [$];
    directed_row_t plan [$];

    int failures = 0;

    // Idling controls. The sender's rate is used only by the driver; the
    // sink's rate and the long hold request are handed over by nonblocking
    // writes so the receiver process sees them cleanly, with no race.
    int send_gap_pct  = 0;
    int sink_hold_pct = 0;
    logic long_hold_req = 1'b0;
    int long_hold_left = 0;

    planar_linear_transform dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Transform model
    // ------------------------------------------------------------------------

    // Sine of angle k * pi / 2^(ANGLE_BITS-1), from a Taylor series in Q30,
    // rounded to Q15. The unit value cannot be held, so it tops out at 32767.
    function automatic longint quarter_sine(longint unsigned k);
        longint unsigned th;
        longint unsigned th2;
        longint unsigned term;
        longint          acc;
        longint          q15;
        int              n;
        th   = (k * PI_Q30_BENCH + (64'd1 << (ANGLE_BITS - 2))) >> (ANGLE_BITS - 1);
        th2  = (th * th) >> 30;
        term = th;
        acc  = longint'(th);
        for (n = 1; n <= 8; n++) begin
            term = (term * th2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        q15 = (acc + 16384) >>> 15;
        if (q15 > 32767) begin
            q15 = 32767;
        end
        return q15;
    endfunction

    // Full-circle sine from the quarter table: odd quadrants read it
    // backwards, the lower half-circle negates.
    function automatic longint sine_of(logic [ANGLE_BITS-1:0] a);
        logic [1:0]            quadrant;
        logic [ANGLE_BITS-3:0] offset;
        longint                mag;
        quadrant = a[ANGLE_BITS-1 -: 2];
        offset   = a[ANGLE_BITS-3:0];
        mag = quadrant[0] ? sine_quarter[QUARTER - offset] : sine_quarter[offset];
        return quadrant[1] ? -mag : mag;
    endfunction

    function automatic longint cosine_of(logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS-1:0] shifted;
        shifted = a + ANGLE_BITS'(QUARTER);
        return sine_of(shifted);
    endfunction

    // Round to nearest with ties toward plus infinity: add half, then floor.
    function automatic longint round_q(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            return COORD_MIN;
        end
        return v;
    endfunction

    // Expected result for one point under the current register copy.
    function automatic point_result_t transform_point(logic signed [COORD_W-1:0] px,
                                                      logic signed [COORD_W-1:0] py);
        longint                x;
        longint                y;
        longint                c;
        longint                s;
        longint                g;
        longint                rx;
        longint                ry;
        logic [ANGLE_BITS-1:0] twice;
        point_result_t         r;
        x = px;
        y = py;
        case (cur_mode)
            MODE_ROTATE: begin
                c  = cosine_of(cur_angle);
                s  = sine_of(cur_angle);
                rx = round_q(c * x - s * y, 15);
                ry = round_q(s * x + c * y, 15);
            end
            MODE_REFLECT: begin
                // The doubled angle wraps around the full circle.
                twice = cur_angle << 1;
                c  = cosine_of(twice);
                s  = sine_of(twice);
                rx = round_q(c * x + s * y, 15);
                ry = round_q(s * x - c * y, 15);
            end
            MODE_PROJECT: begin
                c  = cosine_of(cur_angle);
                s  = sine_of(cur_angle);
                rx = round_q((c * c) * x + (c * s) * y, 30);
                ry = round_q((c * s) * x + (s * s) * y, 30);
            end
            default: begin
                g = cur_gain;
                if (cur_axis) begin
                    rx = round_q(x * 256 + g * y, 8);
                    ry = y;
                end else begin
                    rx = x;
                    ry = round_q(y * 256 + g * x, 8);
                end
            end
        endcase
        r.clipped = (rx != clamp_coord(rx)) || (ry != clamp_coord(ry));
        r.x = COORD_W'(clamp_coord(rx));
        r.y = COORD_W'(clamp_coord(ry));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic void add_write(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
        directed_row_t row;
        row = '{kind: ROW_WRITE, reg_idx: idx, value: value, x: '0, y: '0,
                typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void add_point(logic signed [COORD_W-1:0] x,
                                      logic signed [COORD_W-1:0] y);
        directed_row_t row;
        row = '{kind: ROW_POINT, reg_idx: REG_MODE, value: '0, x: x, y: y,
                typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void add_checked(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y,
                                        logic signed [COORD_W-1:0] ex,
                                        logic signed [COORD_W-1:0] ey,
                                        logic eclip);
        directed_row_t row;
        row = '{kind: ROW_POINT, reg_idx: REG_MODE, value: '0, x: x, y: y,
                typed: 1'b1, want: '{x: ex, y: ey, clipped: eclip}};
        plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------------

    // Mostly full-range coordinates, with corners and small values mixed in.
    function automatic logic signed [COORD_W-1:0] random_coord();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return COORD_W'(COORD_MIN);
                    1: return COORD_W'(COORD_MAX);
                    2: return -1;
                    3: return 0;
                    default: return 1;
                endcase
            end
            1: return COORD_W'($signed($urandom_range(0, 511)) - 256);
            default: return raw[COORD_W-1:0];
        endcase
    endfunction

    // Angles that land on table ends and quadrant boundaries turn up often.
    function automatic logic [ANGLE_BITS-1:0] random_angle();
        logic [31:0] raw;
        raw = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            return raw[ANGLE_BITS-1:0];
        end
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 1;
            2: return ANGLE_BITS'(QUARTER / 2);
            3: return ANGLE_BITS'(QUARTER - 1);
            4: return ANGLE_BITS'(QUARTER);
            5: return ANGLE_BITS'(2 * QUARTER);
            6: return ANGLE_BITS'(3 * QUARTER);
            default: return '1;
        endcase
    endfunction

    // Large gains clip nearly everything, so small ones dominate.
    function automatic logic signed [GAIN_W-1:0] random_gain();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 7))
            0, 1, 2: return raw[GAIN_W-1:0];
            3, 4, 5: return GAIN_W'($signed($urandom_range(0, 2048)) - 1024);
            default: begin
                case ($urandom_range(0, 5))
                    0: return {1'b1, {(GAIN_W - 1){1'b0}}};
                    1: return {1'b0, {(GAIN_W - 1){1'b1}}};
                    2: return 256;
                    3: return -256;
                    4: return 128;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks. Each but set_idling returns just after a rising edge, and
    // each drives a given signal at most once before its first wait, so no
    // signal ever gets two nonblocking writes in one time step.
    // ------------------------------------------------------------------------

    // Stop offering points and wait until every pending result is back.
    // Each point yields exactly one result, so the pipeline is then empty.
    task automatic settle();
        s_tvalid  <= 1'b0;
        cfg_wr_en <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_points.size() != 0);
    endtask

    // The enable is left high; the next task to run lowers it.
    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_MODE:       cur_mode  = map_mode_t'(value[1:0]);
            REG_ANGLE:      cur_angle = value[ANGLE_BITS-1:0];
            REG_SHEAR_AXIS: cur_axis  = value[0];
            default:        cur_gain  = value[GAIN_W-1:0];
        endcase
    endtask

    // Offer one point after a random gap and wait for its input beat.
    // tvalid stays high afterwards so back-to-back beats need no dip.
    task automatic send_point(logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y,
                              bit typed,
                              point_result_t want);
        cfg_wr_en <= 1'b0;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({y, x});
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_points.push_back(typed ? want : transform_point(x, y));
    endtask

    // Writes every register, with junk above the widths of the mode, angle and
    // axis registers that the block has to ignore.
    task automatic apply_random_setting();
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_MODE, {junk[CFG_DATA_W-1:2], 2'($urandom_range(0, 3))});
        junk = $urandom;
        write_reg(REG_ANGLE, {junk[CFG_DATA_W-1:ANGLE_BITS], random_angle()});
        junk = $urandom;
        write_reg(REG_SHEAR_AXIS, {junk[CFG_DATA_W-1:1], 1'($urandom_range(0, 1))});
        write_reg(REG_SHEAR_GAIN, random_gain());
    endtask

    task automatic set_idling(int gap_pct, int hold_pct);
        send_gap_pct  = gap_pct;
        sink_hold_pct <= hold_pct;
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random back-pressure, plus one long hold-off on request.
    // The hold counter lives only in this process.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (long_hold_left > 0) begin
            long_hold_left = long_hold_left - 1;
            m_tready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_left = LONG_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_hold_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Signals are read at the edge before any of this edge's
    // nonblocking updates, so a beat seen here is exactly one the block made.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        point_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                $error("result beat with no point pending: x_out %0d y_out %0d",
                       $signed(m_tdata[COORD_W-1:0]),
                       $signed(m_tdata[2*COORD_W-1:COORD_W]));
                failures = failures + 1;
            end else begin
                want = pending_points.pop_front();
                if (m_tdata[COORD_W-1:0] !== want.x) begin
                    $error("x_out mismatch: expected %0d, actual %0d",
                           want.x, $signed(m_tdata[COORD_W-1:0]));
                    failures = failures + 1;
                end
                if (m_tdata[2*COORD_W-1:COORD_W] !== want.y) begin
                    $error("y_out mismatch: expected %0d, actual %0d",
                           want.y, $signed(m_tdata[2*COORD_W-1:COORD_W]));
                    failures = failures + 1;
                end
                if (m_tuser !== want.clipped) begin
                    $error("clipped mismatch: expected %0d, actual %0d",
                           want.clipped, m_tuser);
                    failures = failures + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int            k;
        int            phase;
        int            set_no;
        int            n;
        directed_row_t row;

        for (k = 0; k <= QUARTER; k++) begin
            sine_quarter[k] = quarter_sine(k);
        end

        // Directed table. Right after reset the map is a rotation by zero,
        // so the origin must come back as the origin.
        add_checked(0, 0, 0, 0, 1'b0);
        add_point(32767, -32768);
        add_point(-32768, 32767);
        // Rotation by a right angle uses the held unit value 32767/32768.
        add_write(REG_ANGLE, 16'd1024);
        add_point(-32768, -32768);
        add_write(REG_ANGLE, 16'd512);
        add_point(32767, 32767);
        add_write(REG_ANGLE, 16'd4095);
        add_point(12345, -23456);
        // Reflection; at 2048 and 3072 the doubled angle wraps around.
        add_write(REG_MODE, MODE_REFLECT);
        add_write(REG_ANGLE, 16'd0);
        add_point(1000, -2000);
        add_write(REG_ANGLE, 16'd2048);
        add_point(-32768, 12345);
        add_write(REG_ANGLE, 16'd3072);
        add_point(32767, -1);
        // Projection onto the axis at the given angle.
        add_write(REG_MODE, MODE_PROJECT);
        add_write(REG_ANGLE, 16'd0);
        add_point(32767, -32768);
        add_write(REG_ANGLE, 16'd512);
        add_point(-32768, -32768);
        add_write(REG_ANGLE, 16'd1024);
        add_point(-32768, 32767);
        // Shear along x with the largest gain saturates both ways.
        add_write(REG_MODE, MODE_SHEAR);
        add_write(REG_SHEAR_AXIS, 16'd1);
        add_write(REG_SHEAR_GAIN, 16'h7fff);
        add_checked(32767, 32767, 32767, 32767, 1'b1);
        add_checked(-32768, -32768, -32768, -32768, 1'b1);
        // A gain of one half lands on exact ties, which round upward.
        add_write(REG_SHEAR_GAIN, 16'd128);
        add_checked(1, 1, 2, 1, 1'b0);
        add_checked(-2, 1, -1, 1, 1'b0);
        // Shear along y: most negative gain, zero gain, unit gain.
        add_write(REG_SHEAR_AXIS, 16'd0);
        add_write(REG_SHEAR_GAIN, 16'h8000);
        add_checked(32767, 0, 32767, -32768, 1'b1);
        add_write(REG_SHEAR_GAIN, 16'd0);
        add_checked(12345, -4321, 12345, -4321, 1'b0);
        add_write(REG_SHEAR_GAIN, 16'd256);
        add_checked(100, 200, 100, 300, 1'b0);
        // Bits above each register's width must be dropped.
        add_write(REG_MODE, 16'hfffc);
        add_write(REG_ANGLE, 16'hf200);
        add_write(REG_SHEAR_AXIS, 16'hfffe);
        add_point(-1, 1);
        add_write(REG_MODE, 16'hfffd);
        add_point(32767, 32767);

        // Sender idles often, sink idles most of the time.
        set_idling(34, 83);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_WRITE) begin
                settle();
                write_reg(row.reg_idx, row.value);
            end else begin
                send_point(row.x, row.y, row.typed, row.want);
            end
        end

        // Random part: a fresh setting every run of points, with the block
        // drained before each change.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       set_idling(34, 83);
                1:       set_idling(83, 34);
                default: set_idling(0, 0);
            endcase
            for (set_no = 0; set_no < SETTINGS_PER_PHASE; set_no++) begin
                settle();
                apply_random_setting();
                // With no idling on either side, hold the sink off for a
                // long stretch while points keep coming, so the pipeline
                // backs up into s_tready.
                if (phase == 2 && set_no == 0) begin
                    long_hold_req <= 1'b1;
                end
                for (n = 0; n < POINTS_PER_SETTING; n++) begin
                    send_point(random_coord(), random_coord(), 1'b0, '0);
                    long_hold_req <= 1'b0;
                    // Once mid-run, pause the sender until all results are in.
                    if (phase == 0 && set_no == 3 && n == POINTS_PER_SETTING / 2) begin
                        settle();
                    end
                end
            end
        end

        // Everything sent: collect the last results, then watch a while
        // longer for any stray beat.
        settle();
        repeat (4 * PIPE_DEPTH) @(posedge aclk);

        if (failures == 0) begin
            $display("planar_linear_transform test passed");
        end else begin
            $display("planar_linear_transform test failed");
        end
        $finish;
    end

    // Safety net in case the block hangs.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("planar_linear_transform test failed");
        $finish;
    end

endmodule
